### design/wrm_pkg.sv
// ----------------------------------------------------------------------------
// wrm_pkg
// shared types and constants for the wildcard pattern matcher: transaction
// structs, operation codes, cell control and controller states
// ----------------------------------------------------------------------------
package wrm_pkg;

  localparam logic [7:0] STAR_CODE = 8'h2A;
  localparam logic [7:0] DOT_CODE  = 8'h2E;

  // cells per propagation group of the zero-occurrence chain
  localparam int GROUP_CELLS = 8;

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_CLEAR  = 2'd1;
  localparam logic [1:0] OP_BEGIN  = 2'd2;
  localparam logic [1:0] OP_TEXT   = 2'd3;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] symbol;
  } in_item_t;

  typedef struct packed {
    logic matched;
    logic overflow;
  } out_item_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_EMPTY,
    CELL_ADVANCE,
    CELL_PROP
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t mode;
    logic [7:0] symbol;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROP,
    ST_FINISH
  } state_t;

endpackage

### design/wildcard_regex_matcher_unit.sv
// ----------------------------------------------------------------------------
// wildcard_regex_matcher_unit
// matches a byte text stream against a stored pattern of literals, '.' and '*'
// ----------------------------------------------------------------------------
// in_ channel: one transaction per operation (append pattern byte, clear
//   pattern, begin text, text byte); out_ channel: one transaction per input
//   with matched and overflow.
// the pattern lives in a chain of MAX_PATTERN cells, one byte and one match
//   bit each. an operation loads the new row in its accept cycle, then the
//   zero-occurrence term of '*' cells ripples through groups of 8 cells, one
//   group per cycle in the propagation state, and the finish state registers
//   the result.
// one transaction is in work at a time: the input stalls from accept until
//   the result is registered, and a dropped append goes straight to the
//   finish state.
// reset empties the pattern and sets the row for an empty text; no clearing
//   pass is needed.
// a stalled result waits in the output register; the controller holds its
//   finished result until the register frees, and the input stays stalled.
// ----------------------------------------------------------------------------
module wildcard_regex_matcher_unit #(
  parameter int MAX_PATTERN = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  wrm_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output wrm_pkg::out_item_t out_data
);
  import wrm_pkg::*;

  localparam int CW = $clog2(MAX_PATTERN + 1);
  localparam int NG = (MAX_PATTERN + GROUP_CELLS) / GROUP_CELLS;
  localparam int IW = (NG > 1) ? $clog2(NG) : 1;

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [IW-1:0] iter_r, iter_nxt;
  logic          m0_r, m0_nxt;
  logic          ovf_r, ovf_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_data_r, out_data_nxt;
  logic          wr_any;
  cell_ctl_t     ctl;

  logic [MAX_PATTERN:0] row;
  logic [MAX_PATTERN:0] prop;
  logic [7:0]           bytes [1:MAX_PATTERN];

  assign row[0]  = m0_r;
  assign prop[0] = m0_r;

  for (genvar j = 1; j <= MAX_PATTERN; j++) begin : g_cell
    logic       has_prev;
    logic [7:0] prev_byte;
    logic       zero_src;
    logic       wr_en;

    if (j == 1) begin : g_first
      assign has_prev  = 1'b0;
      assign prev_byte = 8'h00;
      assign zero_src  = 1'b0;
    end else begin : g_rest
      assign has_prev  = 1'b1;
      assign prev_byte = bytes[j-1];
      if ((j % GROUP_CELLS) >= 2) begin : g_inner
        assign zero_src = prop[j-2];
      end else begin : g_edge
        assign zero_src = row[j-2];
      end
    end

    assign wr_en = wr_any && (count_r == CW'(j - 1));

    wrm_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .wr_en      (wr_en),
      .has_prev   (has_prev),
      .prev_byte  (prev_byte),
      .left_match (row[j-1]),
      .zero_src   (zero_src),
      .byte_q     (bytes[j]),
      .match_q    (row[j]),
      .match_prop (prop[j])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    iter_nxt      = iter_r;
    m0_nxt        = m0_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    wr_any        = 1'b0;
    ctl.mode      = CELL_HOLD;
    ctl.symbol    = in_data.symbol;
    in_stall      = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          iter_nxt  = '0;
          ovf_nxt   = 1'b0;
          state_nxt = ST_PROP;
          unique case (in_data.operation)
            OP_APPEND: begin
              if (count_r == CW'(MAX_PATTERN)) begin
                ovf_nxt   = 1'b1;
                state_nxt = ST_FINISH;
              end else begin
                wr_any    = 1'b1;
                count_nxt = count_r + CW'(1);
                ctl.mode  = CELL_EMPTY;
                m0_nxt    = 1'b1;
              end
            end
            OP_CLEAR: begin
              count_nxt = '0;
              ctl.mode  = CELL_EMPTY;
              m0_nxt    = 1'b1;
            end
            OP_BEGIN: begin
              ctl.mode = CELL_EMPTY;
              m0_nxt   = 1'b1;
            end
            OP_TEXT: begin
              ctl.mode = CELL_ADVANCE;
              m0_nxt   = 1'b0;
            end
            default: begin
              ctl.mode = CELL_HOLD;
            end
          endcase
        end
      end
      ST_PROP: begin
        ctl.mode = CELL_PROP;
        if (iter_r == IW'(NG - 1)) begin
          state_nxt = ST_FINISH;
        end else begin
          iter_nxt = iter_r + IW'(1);
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.matched  = row[count_r];
          out_data_nxt.overflow = ovf_r;
          state_nxt             = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      iter_r      <= '0;
      m0_r        <= 1'b1;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      iter_r      <= iter_nxt;
      m0_r        <= m0_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_accept_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != ST_IDLE))
    else $error("accepted transaction did not start work");

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_PATTERN))
    else $error("pattern count beyond capacity");

  a_overflow_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.overflow && $rose(out_valid)) |-> (count_r == CW'(MAX_PATTERN)))
    else $error("overflow reported with room in the pattern store");

  a_finish_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && !out_valid) |=> (out_valid && state_r == ST_IDLE))
    else $error("finished result not delivered to a free output register");

endmodule

### design/wrm_cell.sv
// ----------------------------------------------------------------------------
// wrm_cell
// one pattern position: holds its pattern byte and its match bit, computes
// the row update from its left neighbors and ors in the zero-occurrence term
// ----------------------------------------------------------------------------
module wrm_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  wrm_pkg::cell_ctl_t ctl,
  input  logic              wr_en,
  input  logic              has_prev,
  input  logic [7:0]        prev_byte,
  input  logic              left_match,
  input  logic              zero_src,
  output logic [7:0]        byte_q,
  output logic              match_q,
  output logic              match_prop
);
  import wrm_pkg::*;

  logic [7:0] byte_r;
  logic       match_r;
  logic       match_nxt;
  logic       is_star;
  logic       lit_hit;
  logic       prev_hit;
  logic       adv_bit;

  assign is_star    = has_prev && (byte_r == STAR_CODE);
  assign lit_hit    = (byte_r == DOT_CODE) || (byte_r == ctl.symbol);
  assign prev_hit   = (prev_byte == DOT_CODE) || (prev_byte == ctl.symbol);
  assign adv_bit    = is_star ? (prev_hit && match_r)
                              : (!(byte_r == STAR_CODE) && lit_hit && left_match);
  assign match_prop = match_r || (is_star && zero_src);

  always_comb begin
    unique case (ctl.mode)
      CELL_EMPTY:   match_nxt = 1'b0;
      CELL_ADVANCE: match_nxt = adv_bit;
      CELL_PROP:    match_nxt = match_prop;
      default:      match_nxt = match_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else begin
      match_r <= match_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      byte_r <= ctl.symbol;
    end
  end

  assign byte_q  = byte_r;
  assign match_q = match_r;

endmodule

### tb/wrm_match_checker.sv
// ----------------------------------------------------------------------------
// wrm_match_checker
// watches both channels of the wildcard pattern matcher, keeps its own copy
// of the pattern and the match row, predicts every accepted input transaction
// and compares each accepted result field by field against the oldest one
// ----------------------------------------------------------------------------
module wrm_match_checker #(
  parameter int MAX_PATTERN = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  wrm_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  wrm_pkg::out_item_t out_data,
  output int                 fail_count,
  output int                 pending
);
  import wrm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0]         pat_bytes [MAX_PATTERN];
  int unsigned        pat_len;
  logic [MAX_PATTERN:0] row_bits;
  out_item_t          predicted_verdicts [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic logic [MAX_PATTERN:0] row_for_empty_text();
    logic [MAX_PATTERN:0] r;
    r    = '0;
    r[0] = 1'b1;
    for (int j = 1; j <= int'(pat_len); j++) begin
      if (j >= 2 && pat_bytes[j-1] == STAR_CODE) begin
        r[j] = r[j-2];
      end
    end
    return r;
  endfunction

  function automatic logic [MAX_PATTERN:0] row_after_byte(logic [7:0] sym);
    logic [MAX_PATTERN:0] nxt;
    logic [7:0]           c;
    logic [7:0]           prev;
    logic                 more;
    nxt = '0;
    for (int j = 1; j <= int'(pat_len); j++) begin
      c = pat_bytes[j-1];
      if (c == STAR_CODE) begin
        // a leading star matches nothing
        if (j >= 2) begin
          prev   = pat_bytes[j-2];
          more   = (prev == DOT_CODE || prev == sym) ? row_bits[j] : 1'b0;
          nxt[j] = nxt[j-2] | more;
        end
      end else if (c == DOT_CODE || c == sym) begin
        nxt[j] = row_bits[j-1];
      end
    end
    return nxt;
  endfunction

  task automatic predict_verdict(input in_item_t it, output out_item_t res);
    res = '0;
    case (it.operation)
      OP_APPEND: begin
        if (pat_len < MAX_PATTERN) begin
          pat_bytes[pat_len] = it.symbol;
          pat_len++;
          row_bits = row_for_empty_text();
        end else begin
          res.overflow = 1'b1;
        end
      end
      OP_CLEAR: begin
        pat_len  = 0;
        row_bits = row_for_empty_text();
      end
      OP_BEGIN: begin
        row_bits = row_for_empty_text();
      end
      default: begin
        row_bits = row_after_byte(it.symbol);
      end
    endcase
    res.matched = row_bits[pat_len];
  endtask

  task automatic report_mismatch(string msg);
    $display("%0t mismatch: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (!rst_n) begin
      pat_len  = 0;
      row_bits = '0;
      row_bits[0] = 1'b1;
      predicted_verdicts.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = out_data;
        if (predicted_verdicts.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected m=%b o=%b",
                                    got.matched, got.overflow));
        end else begin
          want = predicted_verdicts.pop_front();
          if (got.matched !== want.matched) begin
            report_mismatch($sformatf("matched got %b want %b", got.matched, want.matched));
          end
          if (got.overflow !== want.overflow) begin
            report_mismatch($sformatf("overflow got %b want %b",
                                      got.overflow, want.overflow));
          end
        end
      end
      if (in_valid && !in_stall) begin
        predict_verdict(in_data, want);
        predicted_verdicts.push_back(want);
      end
    end
    pending = predicted_verdicts.size();
  end

endmodule

### tb/wildcard_regex_matcher_unit_tb.sv
// ----------------------------------------------------------------------------
// wildcard_regex_matcher_unit_tb
// drives the wildcard pattern matcher with a short directed sequence and then
// with random scenarios: patterns of literals, '.' and '*' followed by texts
// built to fit them (some mutated), overflowing patterns and random noise;
// both channels idle at random and a separate checker predicts and compares
// ----------------------------------------------------------------------------
module wildcard_regex_matcher_unit_tb;
  import wrm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PATTERN = 32;
  localparam int ITEM_TARGET = 1700;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  int        fail_count;
  int        pending;

  int         items_sent;
  bit         burst;
  logic [7:0] pat_q [$];

  wildcard_regex_matcher_unit #(.MAX_PATTERN(MAX_PATTERN)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  wrm_match_checker #(.MAX_PATTERN(MAX_PATTERN)) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 6);
      out_stall <= 1'b0;
      repeat (n) @(posedge clk);
      n = ($urandom_range(0, 6) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3);
      out_stall <= 1'b1;
      repeat (n) @(posedge clk);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic logic [7:0] pick_letter();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return STAR_CODE;
    if (r == 1) return 8'($urandom_range(0, 255));
    return 8'("a") + 8'($urandom_range(0, 2));
  endfunction

  function automatic logic [7:0] pick_pattern_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return STAR_CODE;
    if (r < 30) return DOT_CODE;
    if (r < 95) return 8'("a") + 8'($urandom_range(0, 2));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send(logic [1:0] op, logic [7:0] sym);
    in_item_t it;
    int       gap;
    it.operation = op;
    it.symbol    = sym;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic run_scenario();
    int         len;
    int         reps;
    int         r;
    logic [7:0] b;
    logic [7:0] txt [$];
    burst = ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 9) != 0) begin
      send(OP_CLEAR, 8'($urandom_range(0, 255)));
      pat_q.delete();
    end
    r = $urandom_range(0, 99);
    if (r < 85) len = $urandom_range(1, 8);
    else if (r < 95) len = $urandom_range(9, 24);
    else len = $urandom_range(30, 36);
    repeat (len) begin
      b = pick_pattern_byte();
      send(OP_APPEND, b);
      if (pat_q.size() < MAX_PATTERN) pat_q.push_back(b);
    end
    repeat ($urandom_range(1, 3)) begin
      txt.delete();
      for (int i = 0; i < pat_q.size(); i++) begin
        if (pat_q[i] == STAR_CODE) continue;
        reps = (i + 1 < pat_q.size() && pat_q[i+1] == STAR_CODE) ? $urandom_range(0, 3) : 1;
        repeat (reps) txt.push_back(pat_q[i] == DOT_CODE ? pick_letter() : pat_q[i]);
      end
      if ($urandom_range(0, 3) == 0 && txt.size() > 0) begin
        txt[$urandom_range(0, txt.size() - 1)] = pick_letter();
      end
      if ($urandom_range(0, 5) == 0) txt.push_back(pick_letter());
      if ($urandom_range(0, 3) != 0) send(OP_BEGIN, 8'($urandom_range(0, 255)));
      foreach (txt[i]) send(OP_TEXT, txt[i]);
    end
    // noise
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 6)) begin
        send(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    in_valid   = 1'b0;
    in_data    = '0;
    rst_n      = 1'b0;
    items_sent = 0;
    burst      = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty pattern, leading star, star in text
    send(OP_TEXT,   8'h61);
    send(OP_BEGIN,  8'hFF);
    send(OP_APPEND, STAR_CODE);
    send(OP_TEXT,   STAR_CODE);
    send(OP_CLEAR,  8'h00);
    send(OP_APPEND, 8'h00);
    send(OP_TEXT,   8'h00);
    send(OP_APPEND, 8'hFF);
    send(OP_BEGIN,  8'h00);
    send(OP_TEXT,   8'h00);
    send(OP_TEXT,   8'hFF);
    send(OP_CLEAR,  8'hFF);
    send(OP_APPEND, DOT_CODE);
    send(OP_APPEND, STAR_CODE);
    send(OP_TEXT,   8'hFF);
    send(OP_TEXT,   STAR_CODE);
    send(OP_APPEND, 8'h62);
    send(OP_TEXT,   8'h78);
    send(OP_TEXT,   8'h62);
    send(OP_CLEAR,  8'h00);
    send(OP_APPEND, 8'h61);
    send(OP_APPEND, STAR_CODE);
    send(OP_TEXT,   8'h61);
    send(OP_TEXT,   STAR_CODE);

    while (items_sent < ITEM_TARGET) run_scenario();

    in_valid <= 1'b0;
    // let the checker take in the last accepted transaction
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### filelist.f
design/wrm_pkg.sv
design/wrm_cell.sv
design/wildcard_regex_matcher_unit.sv
tb/wrm_match_checker.sv
tb/wildcard_regex_matcher_unit_tb.sv
